>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tbgd_pkg.sv
package tbgd_pkg;

  localparam int SCORE_W = 16;
  localparam int DIST_W  = 16;
  localparam int ANGLE_W = 15;
  localparam int CELL_W  = 7;
  localparam int CTR_W   = 17;
  localparam int SIZE_W  = 17;
  localparam int DEG_W   = 16;
  localparam int PHASE_W = 16;
  localparam int SINE_W  = 16;
  localparam int DIFF_W  = 17;

  localparam int DEF_CELL_STRIDE = 4;
  localparam int DEF_GRID_DIM    = 128;

  localparam logic [SCORE_W-1:0] MIN_CONF_RESET = 16'd16384;

  // Radians (Q2.13) to phase units (65536 per turn) and to degrees (Q7.8), Q.14 scale.
  localparam logic [14:0] RAD_TO_PHASE = 15'd20861;
  localparam logic [14:0] RAD_TO_DEG   = 15'd29335;

  // Centers are built in units of 2^-21 pixel and reduced to Q13.4.
  localparam int CENTER_SHIFT = 21;
  localparam int REDUCE_SHIFT = 17;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // sin(k * pi / 128) in Q1.14, k = 0..64.
  localparam logic [14:0] QSINE [0:64] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6640,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  function automatic logic [14:0] qsine(input logic [6:0] idx);
    if (idx > 7'd64) begin
      return QSINE[64];
    end
    return QSINE[idx];
  endfunction

  // A kept cell after classification, queued for the geometry back end.
  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic signed [DEG_W-1:0]   angle_deg;
    logic signed [DIFF_W-1:0]  diff_x;     // dist_right - dist_left
    logic signed [DIFF_W-1:0]  diff_y;     // dist_bottom - dist_top
    logic [CELL_W-1:0]         cell_row;
    logic [CELL_W-1:0]         cell_col;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
    logic [SCORE_W-1:0]        score;
  } mid_t;

  typedef struct packed {
    logic signed [CTR_W-1:0]   center_x;
    logic signed [CTR_W-1:0]   center_y;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
    logic signed [DEG_W-1:0]   angle_deg;
    logic [SCORE_W-1:0]        box_score;
  } result_t;

endpackage

>>> rtl/tbgd_fifo.sv
module tbgd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/tbgd_front.sv
module tbgd_front #(
  parameter int GRID_DIM = tbgd_pkg::DEF_GRID_DIM
) (
  input  logic [tbgd_pkg::SCORE_W-1:0]        min_confidence,
  input  logic [tbgd_pkg::SCORE_W-1:0]        score,
  input  logic [tbgd_pkg::DIST_W-1:0]         dist_top,
  input  logic [tbgd_pkg::DIST_W-1:0]         dist_right,
  input  logic [tbgd_pkg::DIST_W-1:0]         dist_bottom,
  input  logic [tbgd_pkg::DIST_W-1:0]         dist_left,
  input  logic signed [tbgd_pkg::ANGLE_W-1:0] angle_rad,
  input  logic [tbgd_pkg::CELL_W-1:0]         cell_row,
  input  logic [tbgd_pkg::CELL_W-1:0]         cell_col,
  output logic                                keep,
  output tbgd_pkg::mid_t                      item
);

  logic        neg;
  logic [14:0] mag;
  logic [29:0] phase_prod;
  logic [29:0] deg_prod;
  logic [15:0] phase_mag;
  logic [15:0] deg_mag;

  // Sign and magnitude of the angle; the most negative code maps to 2 rad, like the rest.
  assign neg = angle_rad[tbgd_pkg::ANGLE_W-1];
  assign mag = neg ? 15'(16'h8000 - {1'b0, $unsigned(angle_rad)}) : $unsigned(angle_rad);

  assign phase_prod = 30'(mag) * 30'(tbgd_pkg::RAD_TO_PHASE) + 30'd8192;
  assign deg_prod   = 30'(mag) * 30'(tbgd_pkg::RAD_TO_DEG) + 30'd8192;
  assign phase_mag  = phase_prod[29:14];
  assign deg_mag    = deg_prod[29:14];

  assign keep = (score >= min_confidence) &&
                (int'(cell_row) < GRID_DIM) &&
                (int'(cell_col) < GRID_DIM);

  always_comb begin
    item.phase      = neg ? (16'd0 - phase_mag) : phase_mag;
    // The output angle is the negated input angle.
    item.angle_deg  = neg ? $signed(deg_mag) : $signed(16'd0 - deg_mag);
    item.diff_x     = $signed({1'b0, dist_right}) - $signed({1'b0, dist_left});
    item.diff_y     = $signed({1'b0, dist_bottom}) - $signed({1'b0, dist_top});
    item.cell_row   = cell_row;
    item.cell_col   = cell_col;
    item.box_width  = 17'(dist_right) + 17'(dist_left);
    item.box_height = 17'(dist_top) + 17'(dist_bottom);
    item.score      = score;
  end

endmodule

>>> rtl/tbgd_back.sv
module tbgd_back #(
  parameter int CELL_STRIDE = tbgd_pkg::DEF_CELL_STRIDE,
  parameter int OUT_DEPTH   = tbgd_pkg::OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               mid_empty,
  input  tbgd_pkg::mid_t                     mid_item,
  output logic                               mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               out_push,
  output tbgd_pkg::result_t                  out_item
);

  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
  localparam int OX_W   = $clog2(((1 << tbgd_pkg::CELL_W) - 1) * CELL_STRIDE + 1);
  localparam int BASE_W = OX_W + tbgd_pkg::CENTER_SHIFT + 1;
  localparam int PROD_W = tbgd_pkg::SINE_W + tbgd_pkg::DIFF_W;
  localparam int SUM_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;
  localparam int SHR_W  = SUM_W - tbgd_pkg::REDUCE_SHIFT;

  localparam logic signed [SHR_W-1:0] Q_MIN = SHR_W'(-65536);
  localparam logic signed [SHR_W-1:0] Q_MAX = SHR_W'(65535);

  // Table entries around one quarter-wave point, with the quadrant sign.
  typedef struct packed {
    logic        neg;
    logic [14:0] lo;
    logic [8:0]  diff;
    logic [7:0]  frac;
  } fold_t;

  function automatic fold_t fold(input logic [tbgd_pkg::PHASE_W-1:0] ph);
    fold_t       f;
    logic [14:0] arg;
    logic [6:0]  idx;
    logic [14:0] hi;
    arg    = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    idx    = arg[14:8];
    f.lo   = tbgd_pkg::qsine(idx);
    hi     = (idx >= 7'd64) ? tbgd_pkg::qsine(7'd64) : tbgd_pkg::qsine(idx + 7'd1);
    f.diff = 9'(hi - f.lo);
    f.frac = arg[7:0];
    f.neg  = ph[15];
    return f;
  endfunction

  function automatic logic signed [tbgd_pkg::SINE_W-1:0] interp(input fold_t f);
    logic [17:0] prod;
    logic [14:0] v;
    prod = 18'(f.diff) * 18'(f.frac) + 18'd128;
    v    = f.lo + 15'(prod[17:8]);
    return f.neg ? $signed(16'd0 - 16'(v)) : $signed(16'(v));
  endfunction

  function automatic logic signed [tbgd_pkg::CTR_W-1:0] reduce(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SHR_W-1:0] q;
    q = $signed(v[SUM_W-1:tbgd_pkg::REDUCE_SHIFT]);
    if (q < Q_MIN) begin
      return tbgd_pkg::CTR_W'(Q_MIN);
    end else if (q > Q_MAX) begin
      return tbgd_pkg::CTR_W'(Q_MAX);
    end
    return tbgd_pkg::CTR_W'(q);
  endfunction

  // Stage A: quarter-wave table reads.
  logic                      a_vld_r;
  tbgd_pkg::mid_t            a_item_r;
  fold_t                     a_sin_r, a_cos_r;
  // Stage B: sine and cosine.
  logic                      b_vld_r;
  tbgd_pkg::mid_t            b_item_r;
  logic signed [tbgd_pkg::SINE_W-1:0] b_sin_r, b_cos_r;
  // Stage C: rotated products.
  logic                      c_vld_r;
  tbgd_pkg::mid_t            c_item_r;
  logic signed [PROD_W-1:0]  c_cdx_r, c_sdy_r, c_cdy_r, c_sdx_r;

  logic [CNT_W:0]            reserved;
  logic [tbgd_pkg::PHASE_W-1:0] cos_phase;
  logic [OX_W-1:0]           ox, oy;
  logic signed [SUM_W-1:0]   base_x, base_y, sum_x, sum_y;

  // Output slots already taken or promised to items still in the pipeline.
  assign reserved = {1'b0, out_count} + (CNT_W + 1)'(a_vld_r) + (CNT_W + 1)'(b_vld_r) +
                    (CNT_W + 1)'(c_vld_r);
  assign mid_pop  = !mid_empty && (reserved < (CNT_W + 1)'(OUT_DEPTH));

  assign cos_phase = mid_item.phase + 16'd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= mid_pop;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= mid_item;
    a_sin_r  <= fold(mid_item.phase);
    a_cos_r  <= fold(cos_phase);
    b_item_r <= a_item_r;
    b_sin_r  <= interp(a_sin_r);
    b_cos_r  <= interp(a_cos_r);
    c_item_r <= b_item_r;
    c_cdx_r  <= b_cos_r * b_item_r.diff_x;
    c_sdy_r  <= b_sin_r * b_item_r.diff_y;
    c_cdy_r  <= b_cos_r * b_item_r.diff_y;
    c_sdx_r  <= b_sin_r * b_item_r.diff_x;
  end

  // Stage D: cell offset plus rotated distances, then reduce and saturate.
  assign ox = OX_W'(c_item_r.cell_col * CELL_STRIDE);
  assign oy = OX_W'(c_item_r.cell_row * CELL_STRIDE);
  // The half-step rounding constant sits below the offset bits.
  assign base_x = $signed(SUM_W'({ox, 21'd65536}));
  assign base_y = $signed(SUM_W'({oy, 21'd65536}));
  assign sum_x  = base_x + c_cdx_r + c_sdy_r;
  assign sum_y  = base_y + c_cdy_r - c_sdx_r;

  assign out_push = c_vld_r;

  always_comb begin
    out_item.center_x   = reduce(sum_x);
    out_item.center_y   = reduce(sum_y);
    out_item.box_width  = c_item_r.box_width;
    out_item.box_height = c_item_r.box_height;
    out_item.angle_deg  = c_item_r.angle_deg;
    out_item.box_score  = c_item_r.score;
  end

endmodule

>>> rtl/text_box_geometry_decode_unit.sv
// Rotated text box decoder, one detector feature-map cell per item.
// Input channel: drive the cell fields and raise push; the item is taken at
// a rising edge of clk where push is high and full is low. One item can be
// taken every cycle.
// Result channel: while empty is low the oldest box is on the out_ ports;
// raise pop to take it. Cells scoring below cfg min confidence, or lying
// outside the grid, give no box and are simply consumed.
// A kept item passes the front classify, the middle queue, table read, sine
// interpolation, products, then the center sum into the result queue, where
// it shows up on the result ports. Throughput is one item per cycle, set by
// the fully pipelined back end and its four product multipliers.
// When the receiver stops popping, the eight-entry result queue fills, the
// back end stops drawing from the four-entry middle queue, and full rises
// once that queue is also full; nothing is lost. The confidence threshold is
// written by the user through cfg_wr_en / cfg_wr_data only while the block
// is idle; the block does not enforce this. Synchronous reset (rst_n low)
// empties both queues, clears the pipeline and sets the threshold to 0.5.
`include "assert_macros.svh"

module text_box_geometry_decode_unit #(
  parameter int CELL_STRIDE = tbgd_pkg::DEF_CELL_STRIDE,
  parameter int GRID_DIM    = tbgd_pkg::DEF_GRID_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [tbgd_pkg::SCORE_W-1:0]        cfg_wr_data,
  // input channel
  input  logic                                push,
  output logic                                full,
  input  logic [tbgd_pkg::SCORE_W-1:0]        in_score,
  input  logic [tbgd_pkg::DIST_W-1:0]         in_dist_top,
  input  logic [tbgd_pkg::DIST_W-1:0]         in_dist_right,
  input  logic [tbgd_pkg::DIST_W-1:0]         in_dist_bottom,
  input  logic [tbgd_pkg::DIST_W-1:0]         in_dist_left,
  input  logic signed [tbgd_pkg::ANGLE_W-1:0] in_angle_rad,
  input  logic [tbgd_pkg::CELL_W-1:0]         in_cell_row,
  input  logic [tbgd_pkg::CELL_W-1:0]         in_cell_col,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic signed [tbgd_pkg::CTR_W-1:0]   out_center_x,
  output logic signed [tbgd_pkg::CTR_W-1:0]   out_center_y,
  output logic [tbgd_pkg::SIZE_W-1:0]         out_box_width,
  output logic [tbgd_pkg::SIZE_W-1:0]         out_box_height,
  output logic signed [tbgd_pkg::DEG_W-1:0]   out_angle_deg,
  output logic [tbgd_pkg::SCORE_W-1:0]        out_box_score
);

  localparam int MID_W     = $bits(tbgd_pkg::mid_t);
  localparam int RES_W     = $bits(tbgd_pkg::result_t);
  localparam int OUT_CNT_W = $clog2(tbgd_pkg::OUT_DEPTH + 1);

  logic [tbgd_pkg::SCORE_W-1:0] min_confidence_r, min_confidence_nxt;

  logic               keep;
  tbgd_pkg::mid_t     front_item;
  logic               mid_push, mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0]   mid_head;

  logic               out_push, out_full;
  tbgd_pkg::result_t  back_item;
  tbgd_pkg::result_t  head_item;
  logic [RES_W-1:0]   out_head;
  logic [OUT_CNT_W-1:0] out_count;

  // Threshold register.
  assign min_confidence_nxt = cfg_wr_en ? cfg_wr_data : min_confidence_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_confidence_r <= tbgd_pkg::MIN_CONF_RESET;
    end else begin
      min_confidence_r <= min_confidence_nxt;
    end
  end

  // Front end: threshold and grid check, angle to phase and degrees.
  tbgd_front #(
    .GRID_DIM (GRID_DIM)
  ) u_front (
    .min_confidence (min_confidence_r),
    .score          (in_score),
    .dist_top       (in_dist_top),
    .dist_right     (in_dist_right),
    .dist_bottom    (in_dist_bottom),
    .dist_left      (in_dist_left),
    .angle_rad      (in_angle_rad),
    .cell_row       (in_cell_row),
    .cell_col       (in_cell_col),
    .keep           (keep),
    .item           (front_item)
  );

  // Every accepted item leaves the input side; only kept cells are queued.
  assign full     = mid_full;
  assign mid_push = push && !mid_full && keep;

  tbgd_fifo #(
    .WIDTH (MID_W),
    .DEPTH (tbgd_pkg::MID_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (front_item),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_head),
    .empty     (mid_empty),
    .count     ()
  );

  // Back end: sine and cosine, rotated center, saturation.
  tbgd_back #(
    .CELL_STRIDE (CELL_STRIDE),
    .OUT_DEPTH   (tbgd_pkg::OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (tbgd_pkg::mid_t'(mid_head)),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (back_item)
  );

  // Result queue; the back end only issues an item when a slot is reserved.
  tbgd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (tbgd_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (out_push),
    .push_data (back_item),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_head),
    .empty     (empty),
    .count     (out_count)
  );

  assign head_item      = tbgd_pkg::result_t'(out_head);
  assign out_center_x   = head_item.center_x;
  assign out_center_y   = head_item.center_y;
  assign out_box_width  = head_item.box_width;
  assign out_box_height = head_item.box_height;
  assign out_angle_deg  = head_item.angle_deg;
  assign out_box_score  = head_item.box_score;

  // The slot reservation must keep the result queue from ever overflowing.
  `ASSERT_IMPL(a_out_no_overflow, out_push, !out_full, "result queue overflow")
  // The back end must never draw from an empty middle queue.
  `ASSERT_IMPL(a_mid_pop_valid, mid_pop, !mid_empty, "pop from empty middle queue")
  // A cell below threshold must never reach the back end.
  `ASSERT_IMPL(a_drop_low_score, push && !full && (in_score < min_confidence_r), !mid_push,
    "low-score cell queued")
  // A box issued by the back end is visible on the result side next cycle.
  `ASSERT_NEXT(a_push_shows, out_push, !empty, "issued box not visible")

endmodule

>>> verif/text_box_geometry_decode_unit_tb.sv
`timescale 1ns / 100ps

module text_box_geometry_decode_unit_tb;

  // The run is cut off at this many clock cycles. A correct run needs only a
  // small fraction of it, even with both sides idling at their most.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // This many quiet cycles after the last box are a safe margin before a
  // threshold write or the end of the run.
  localparam int SETTLE_CYCLES = 8;

  localparam int CELL_STRIDE = 4;
  localparam int GRID_DIM    = 128;

  localparam int RAD_TO_PHASE_Q14 = 20861;
  localparam int RAD_TO_DEG_Q14   = 29335;

  localparam longint CENTER_LOW  = -65536;
  localparam longint CENTER_HIGH = 65535;

  // sin(k * pi / 128) in Q1.14 for k = 0..64, the first quarter of a turn.
  localparam int QUARTER_WAVE [65] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801,
    3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
    6270, 6640, 7005, 7366, 7723, 8076, 8423, 8765,
    9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
    11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
    15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
    16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
    16384
  };

  // One feature-map cell as it goes into the block. The angle is kept as a
  // raw 15-bit vector; its sign bit is decoded by the predictor.
  typedef struct packed {
    logic [15:0] score;
    logic [15:0] dist_top;
    logic [15:0] dist_right;
    logic [15:0] dist_bottom;
    logic [15:0] dist_left;
    logic [14:0] angle_rad;
    logic [6:0]  cell_row;
    logic [6:0]  cell_col;
  } cell_t;

  // Where the outcome of an item is plain to see, it is typed in by hand;
  // otherwise the predictor works it out when the item is accepted.
  typedef struct packed {
    logic                 typed;
    logic                 kept;
    tbgd_pkg::result_t    box;
  } known_outcome_t;

  typedef struct packed {
    cell_t          cell_in;
    known_outcome_t outcome;
  } directed_row_t;

  // The directed items. The first six have their outcome typed in: a cell at
  // the origin, cells just below and at the reset threshold, a score above
  // one with the largest distances, a zero score, and a corner cell whose
  // center goes negative. The rest cover the angle extremes (plus and minus
  // pi/2, the largest and the most negative 15-bit code, which lie beyond
  // pi/2), the smallest angles, plus and minus pi/4, alternating bit patterns
  // on the distances and angles, and plus and minus one radian.
  localparam int DIRECTED_COUNT = 18;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{16'd32768, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 7'd0, 7'd0},
      '{1'b1, 1'b1, '{17'd0, 17'd0, 17'd0, 17'd0, 16'd0, 16'd32768}}},
    '{'{16'd16383, 16'd100, 16'd200, 16'd300, 16'd400, 15'd0, 7'd5, 7'd5},
      '{1'b1, 1'b0, '0}},
    '{'{16'd16384, 16'd0, 16'd65535, 16'd65535, 16'd0, 15'd0, 7'd127, 7'd127},
      '{1'b1, 1'b1, '{17'd16320, 17'd16320, 17'd65535, 17'd65535, 16'd0, 16'd16384}}},
    '{'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 15'd0, 7'd0, 7'd0},
      '{1'b1, 1'b1, '{17'd0, 17'd0, 17'd131070, 17'd131070, 16'd0, 16'd65535}}},
    '{'{16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 15'd0, 7'd9, 7'd9},
      '{1'b1, 1'b0, '0}},
    '{'{16'd32768, 16'd65535, 16'd0, 16'd0, 16'd65535, 15'd0, 7'd127, 7'd0},
      '{1'b1, 1'b1, '{-17'sd8192, -17'sd64, 17'd65535, 17'd65535, 16'd0, 16'd32768}}},
    '{'{16'd40000, 16'd1000, 16'd2000, 16'd3000, 16'd4000, 15'd12868, 7'd10, 7'd20},
      '{1'b0, 1'b0, '0}},
    '{'{16'd32768, 16'd1000, 16'd2000, 16'd3000, 16'd4000, 15'h4DBC, 7'd20, 7'd10},
      '{1'b0, 1'b0, '0}},
    '{'{16'd32768, 16'd65535, 16'd0, 16'd65535, 16'd0, 15'h3FFF, 7'd127, 7'd127},
      '{1'b0, 1'b0, '0}},
    '{'{16'd32768, 16'd0, 16'd65535, 16'd0, 16'd65535, 15'h4000, 7'd0, 7'd127},
      '{1'b0, 1'b0, '0}},
    '{'{16'd20000, 16'd64, 16'd64, 16'd64, 16'd64, 15'd1, 7'd85, 7'd42},
      '{1'b0, 1'b0, '0}},
    '{'{16'd20000, 16'd64, 16'd64, 16'd64, 16'd64, 15'h7FFF, 7'd42, 7'd85},
      '{1'b0, 1'b0, '0}},
    '{'{16'd30000, 16'd12345, 16'd54321, 16'd11111, 16'd22222, 15'd6434, 7'd64, 7'd64},
      '{1'b0, 1'b0, '0}},
    '{'{16'd30000, 16'd12345, 16'd54321, 16'd11111, 16'd22222, 15'h66DE, 7'd1, 7'd126},
      '{1'b0, 1'b0, '0}},
    '{'{16'd32768, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA, 7'd127, 7'd0},
      '{1'b0, 1'b0, '0}},
    '{'{16'd32768, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555, 7'd0, 7'd127},
      '{1'b0, 1'b0, '0}},
    '{'{16'd16384, 16'd1, 16'd2, 16'd3, 16'd4, 15'd8192, 7'd3, 7'd4},
      '{1'b0, 1'b0, '0}},
    '{'{16'd16385, 16'd500, 16'd500, 16'd500, 16'd500, 15'h6000, 7'd100, 7'd27},
      '{1'b0, 1'b0, '0}}
  };

  // Random phases. Each runs under its own threshold (the extremes, 32768,
  // one just above zero, a random one and the reset value) and its own idling,
  // so that gaps land on every stage of the pipeline. Phase 0 also opens with a
  // long hold on the result side while cells stream in back to back.
  localparam int PHASE_COUNT      = 6;
  localparam int ITEMS_PER_PHASE  = 222;
  localparam int RANDOM_THRESHOLD = -1;
  localparam int PHASE_THRESHOLD [PHASE_COUNT] = '{0, 32768, 65535, 1, RANDOM_THRESHOLD, 16384};
  localparam int PHASE_CELL_GAP  [PHASE_COUNT] = '{0, 18, 0, 0, 6, 18};
  localparam int PHASE_BOX_GAP   [PHASE_COUNT] = '{18, 0, 0, 18, 6, 18};
  localparam int LONG_HOLD_CYCLES = 120;

  localparam logic [15:0] SCORE_CORNERS [3] = '{16'd0, 16'd32768, 16'hFFFF};
  // Zero, plus pi/2, minus pi/2, and the two ends of the 15-bit code range.
  localparam logic [14:0] ANGLE_CORNERS [5] = '{15'd0, 15'd12868, 15'h4DBC, 15'h3FFF, 15'h4000};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  logic        push           = 1'b0;
  logic        full;
  logic [15:0] in_score       = '0;
  logic [15:0] in_dist_top    = '0;
  logic [15:0] in_dist_right  = '0;
  logic [15:0] in_dist_bottom = '0;
  logic [15:0] in_dist_left   = '0;
  logic [14:0] in_angle_rad   = '0;
  logic [6:0]  in_cell_row    = '0;
  logic [6:0]  in_cell_col    = '0;

  logic               empty;
  logic               pop = 1'b0;
  logic signed [16:0] out_center_x;
  logic signed [16:0] out_center_y;
  logic [16:0]        out_box_width;
  logic [16:0]        out_box_height;
  logic signed [15:0] out_angle_deg;
  logic [15:0]        out_box_score;

  // The testbench's own copy of the threshold register.
  logic [15:0] min_confidence_now = 16'd16384;

  // Outcomes staged by the sender, one per item in the order of sending, and
  // the boxes still owed by the block, oldest first.
  known_outcome_t    staged_outcomes[$];
  tbgd_pkg::result_t pending_boxes[$];

  int          cell_gap_max = 0;
  int          box_gap_max  = 0;
  int          result_hold  = 0;
  int          error_count  = 0;
  int unsigned cycle_count  = 0;

  text_box_geometry_decode_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .push           (push),
    .full           (full),
    .in_score       (in_score),
    .in_dist_top    (in_dist_top),
    .in_dist_right  (in_dist_right),
    .in_dist_bottom (in_dist_bottom),
    .in_dist_left   (in_dist_left),
    .in_angle_rad   (in_angle_rad),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .empty          (empty),
    .pop            (pop),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_box_width  (out_box_width),
    .out_box_height (out_box_height),
    .out_angle_deg  (out_angle_deg),
    .out_box_score  (out_box_score)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Sine over the first quadrant, r from 0 to 16384 (a quarter turn), by
  // linear interpolation between table entries with rounding half up.
  function automatic int quarter_sine(input int r);
    int idx;
    int frac;
    int lo;
    int hi;
    idx  = r >> 8;
    frac = r & 255;
    if (idx >= 64) begin
      return QUARTER_WAVE[64];
    end
    lo = QUARTER_WAVE[idx];
    hi = QUARTER_WAVE[idx + 1];
    return lo + (((hi - lo) * frac + 128) >>> 8);
  endfunction

  // Sine of a phase with 65536 units per turn, folded onto the first quadrant.
  function automatic int sine_of_phase(input logic [15:0] phase);
    int r;
    r = int'(phase[13:0]);
    case (phase[15:14])
      2'd0: return quarter_sine(r);
      2'd1: return quarter_sine(16384 - r);
      2'd2: return -quarter_sine(r);
      default: return -quarter_sine(16384 - r);
    endcase
  endfunction

  // Reduces a center in units of 2^-21 pixel to Q13.4, rounding half up
  // (floor after adding half a step), and saturates it to 17 bits.
  function automatic logic signed [16:0] center_to_q13_4(input longint v);
    longint q;
    q = (v + 65536) >>> 17;
    if (q < CENTER_LOW) begin
      q = CENTER_LOW;
    end
    if (q > CENTER_HIGH) begin
      q = CENTER_HIGH;
    end
    return 17'(q);
  endfunction

  // Decodes one cell into its rotated box. Returns 0 when the cell is dropped.
  function automatic bit decode_cell(input cell_t cell_in, input logic [15:0] threshold,
                                     output tbgd_pkg::result_t box);
    bit          neg;
    int unsigned mag;
    int unsigned phase;
    int unsigned deg;
    longint      sn;
    longint      cs;
    longint      dt;
    longint      dr;
    longint      db;
    longint      dl;
    longint      w;
    longint      h;
    longint      ox;
    longint      oy;
    longint      cx;
    longint      cy;
    box = '0;
    if (cell_in.score < threshold) begin
      return 1'b0;
    end
    if (int'(cell_in.cell_row) >= GRID_DIM || int'(cell_in.cell_col) >= GRID_DIM) begin
      return 1'b0;
    end
    neg = cell_in.angle_rad[14];
    mag = neg ? (32'h8000 - {17'd0, cell_in.angle_rad}) : {17'd0, cell_in.angle_rad};
    phase = (mag * RAD_TO_PHASE_Q14 + 8192) >> 14;
    if (neg) begin
      phase = (32'h10000 - phase) & 32'hFFFF;
    end
    sn = sine_of_phase(phase[15:0]);
    cs = sine_of_phase(16'(phase + 16384));

    dt = cell_in.dist_top;
    dr = cell_in.dist_right;
    db = cell_in.dist_bottom;
    dl = cell_in.dist_left;
    h  = dt + db;
    w  = dr + dl;
    ox = longint'(cell_in.cell_col) * CELL_STRIDE;
    oy = longint'(cell_in.cell_row) * CELL_STRIDE;

    // The end point sits at the right and bottom distances from the cell,
    // rotated; the center lies half the box back from it.
    cx = ox * 2097152 + 2 * (cs * dr + sn * db) - (sn * h + cs * w);
    cy = oy * 2097152 + 2 * (cs * db - sn * dr) + (sn * w - cs * h);

    deg = (mag * RAD_TO_DEG_Q14 + 8192) >> 14;

    box.center_x   = center_to_q13_4(cx);
    box.center_y   = center_to_q13_4(cy);
    box.box_width  = 17'(w);
    box.box_height = 17'(h);
    box.angle_deg  = neg ? 16'(deg) : 16'(32'h10000 - deg);
    box.box_score  = cell_in.score;
    return 1'b1;
  endfunction

  function automatic logic [15:0] random_distance();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 1023));
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random cell content. Scores cluster around the threshold now and then so
  // that both sides of the compare are hit often; a few scores and angles go
  // beyond their nominal ranges to reach every code of the fields.
  function automatic cell_t random_cell(input logic [15:0] threshold);
    cell_t cell_in;
    int    pick;
    int    near;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      cell_in.score = 16'($urandom_range(0, 32768));
    end else if (pick == 6) begin
      cell_in.score = 16'($urandom);
    end else if (pick < 9) begin
      near = int'(threshold) + int'($urandom_range(0, 4)) - 2;
      cell_in.score = (near < 0) ? 16'd0 : (near > 65535) ? 16'hFFFF : 16'(near);
    end else begin
      cell_in.score = SCORE_CORNERS[$urandom_range(0, 2)];
    end
    cell_in.dist_top    = random_distance();
    cell_in.dist_right  = random_distance();
    cell_in.dist_bottom = random_distance();
    cell_in.dist_left   = random_distance();
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      cell_in.angle_rad = 15'(int'($urandom_range(0, 25736)) - 12868);
    end else if (pick == 7) begin
      cell_in.angle_rad = 15'($urandom);
    end else if (pick == 8) begin
      cell_in.angle_rad = ANGLE_CORNERS[$urandom_range(0, 4)];
    end else begin
      cell_in.angle_rad = 15'(int'($urandom_range(0, 128)) - 64);
    end
    cell_in.cell_row = 7'($urandom);
    cell_in.cell_col = 7'($urandom);
    return cell_in;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Offers one item after a random gap. The push line stays high from one
  // item to the next when the gap is zero, so it is never lowered and raised
  // in the same time step.
  task automatic send_cell(input cell_t cell_in, input known_outcome_t outcome);
    int gap;
    gap = $urandom_range(0, cell_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    staged_outcomes = {staged_outcomes, outcome};
    push           <= 1'b1;
    in_score       <= cell_in.score;
    in_dist_top    <= cell_in.dist_top;
    in_dist_right  <= cell_in.dist_right;
    in_dist_bottom <= cell_in.dist_bottom;
    in_dist_left   <= cell_in.dist_left;
    in_angle_rad   <= cell_in.angle_rad;
    in_cell_row    <= cell_in.cell_row;
    in_cell_col    <= cell_in.cell_col;
    do @(posedge clk); while (full);
  endtask

  // Stops sending and waits until every box owed has been taken, then lets
  // the block sit quiet for a few more cycles.
  task automatic wait_until_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en          <= 1'b0;
    min_confidence_now = value;
  endtask

  // Checker. Both channels are sampled at the rising edge, where the values
  // seen are those from before the edge. An accepted item either takes its
  // hand-typed outcome or is run through the predictor; each accepted box is
  // compared with the oldest box owed.
  always @(posedge clk) begin : scoreboard
    known_outcome_t    outcome;
    tbgd_pkg::result_t want;
    cell_t             cell_in;
    bit                kept;
    if (rst_n && push && !full) begin
      cell_in = '{in_score, in_dist_top, in_dist_right, in_dist_bottom, in_dist_left,
                  in_angle_rad, in_cell_row, in_cell_col};
      outcome = (staged_outcomes.size() != 0) ? staged_outcomes.pop_front() : '0;
      if (outcome.typed) begin
        kept = outcome.kept;
        want = outcome.box;
      end else begin
        kept = decode_cell(cell_in, min_confidence_now, want);
      end
      if (kept) begin
        pending_boxes = {pending_boxes, want};
      end
    end
    if (rst_n && pop && !empty) begin
      if (pending_boxes.size() == 0) begin
        $display("%0t: box with none expected, got center (%0d, %0d)", $time,
                 out_center_x, out_center_y);
        error_count++;
      end else begin
        want = pending_boxes.pop_front();
        check_field("center_x", want.center_x, out_center_x);
        check_field("center_y", want.center_y, out_center_y);
        check_field("box_width", want.box_width, out_box_width);
        check_field("box_height", want.box_height, out_box_height);
        check_field("angle_deg", want.angle_deg, out_angle_deg);
        check_field("box_score", want.box_score, out_box_score);
      end
    end
  end

  // Result side. Before each box it waits a random number of cycles. When a
  // long hold is asked for, it holds off for that many cycles here, on its
  // own count, while the sender keeps offering items.
  initial begin : result_taker
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (result_hold > 0) begin
        pop <= 1'b0;
        repeat (result_hold) @(posedge clk);
        result_hold = 0;
      end
      gap = $urandom_range(0, box_gap_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty && result_hold == 0);
    end
  end

  initial begin : timeout_guard
    wait (cycle_count >= CYCLE_LIMIT);
    $display("text_box_geometry_decode_unit test failed");
    $finish;
  end

  // Main sequence: reset, the directed items under the reset threshold, then
  // the random phases, each started from an idle block with a fresh threshold.
  initial begin : stimulus
    int             phase;
    int             n;
    logic [15:0]    threshold;
    known_outcome_t no_typed;
    no_typed = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cell_gap_max = 3;
    box_gap_max  = 3;
    for (n = 0; n < DIRECTED_COUNT; n++) begin
      send_cell(DIRECTED_ROWS[n].cell_in, DIRECTED_ROWS[n].outcome);
    end

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_until_idle();
      if (PHASE_THRESHOLD[phase] == RANDOM_THRESHOLD) begin
        threshold = 16'($urandom_range(1, 32767));
      end else begin
        threshold = 16'(PHASE_THRESHOLD[phase]);
      end
      write_threshold(threshold);
      cell_gap_max = PHASE_CELL_GAP[phase];
      box_gap_max  = PHASE_BOX_GAP[phase];
      // With every cell kept and no sender gaps, this hold fills both
      // internal queues and forces full high for a good stretch.
      if (phase == 0) begin
        result_hold = LONG_HOLD_CYCLES;
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cell(random_cell(threshold), no_typed);
      end
    end

    wait_until_idle();
    if (error_count == 0) begin
      $display("text_box_geometry_decode_unit test passed");
    end else begin
      $display("text_box_geometry_decode_unit test failed");
    end
    $finish;
  end

endmodule

>>> text_box_geometry_decode_unit.f
+incdir+rtl
rtl/tbgd_pkg.sv
rtl/tbgd_fifo.sv
rtl/tbgd_front.sv
rtl/tbgd_back.sv
rtl/text_box_geometry_decode_unit.sv
verif/text_box_geometry_decode_unit_tb.sv
